### design/vat_pkg.sv
// vat_pkg: shared types and constants for the vertex affine transform and pick block
// opcodes, register indexes, field widths and the coordinate saturation helper
// no dependencies
package vat_pkg;

   // store depth default
   localparam int MAX_VERTICES_DEF = 64;

   // field widths
   localparam int COORD_W  = 24;
   localparam int SCALE_W  = 16;
   localparam int OP_W     = 3;
   localparam int INDEX_W  = 6;
   localparam int TOTAL_W  = 7;
   localparam int CSR_IDX_W = 3;

   // pick radius factor and the bits it needs
   localparam int PICK_FACTOR = 10;
   localparam int RADIUS_W    = 12;

   // register reset values
   localparam logic signed [COORD_W-1:0] COEF_ONE  = 24'sd65536;
   localparam logic signed [COORD_W-1:0] COEF_ZERO = 24'sd0;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_RESTORE   = 3'd2,
      OP_TRANSFORM = 3'd3,
      OP_PICK      = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_XX  = 3'd0,
      CSR_COEF_XY  = 3'd1,
      CSR_OFFSET_X = 3'd2,
      CSR_COEF_YX  = 3'd3,
      CSR_COEF_YY  = 3'd4,
      CSR_OFFSET_Y = 3'd5
   } csr_idx_type;

   // clamp a 34 bit signed value to the 24 bit coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [33:0] v);
      logic signed [33:0] lo;
      logic signed [33:0] hi;
      lo = -34'sd8388608;
      hi = 34'sd8388607;
      if (v < lo) begin
         sat_coord = -24'sd8388608;
      end else if (v > hi) begin
         sat_coord = 24'sd8388607;
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

endpackage

### design/vertex_affine_transform_pick.sv
// vertex_affine_transform_pick: vertex store with 2d affine transform and point pick
// keeps original and current vertex copies in two synchronous memories
// depends on vat_pkg
//
// load, clear and unused opcodes: result strobe in the cycle after the command is taken,
// busy stays low. restore, transform and pick with N stored vertices: one vertex read
// per cycle from the store memories through a three stage read, multiply, write-back
// pipeline; busy stays high until the pipeline has drained, then the strobe comes.
// with an empty store these also answer like load and clear, with busy low.
// synchronous reset clears the vertex count and loads the identity transform; memory
// contents are not cleared. the receiver cannot stall, results are never held.
module vertex_affine_transform_pick
   import vat_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [OP_W-1:0]             req_opcode,
   input  logic signed [COORD_W-1:0]   req_coord_x,
   input  logic signed [COORD_W-1:0]   req_coord_y,
   input  logic [SCALE_W-1:0]          req_pick_scale,
   // result channel
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [INDEX_W-1:0]          rsp_hit_index,
   output logic [TOTAL_W-1:0]          rsp_vertex_total,
   output logic                        rsp_load_rejected,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic signed [COORD_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = 2 * COORD_W;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // transform registers
   logic signed [COORD_W-1:0] coef_xx_ff, coef_xy_ff, offset_x_ff;
   logic signed [COORD_W-1:0] coef_yx_ff, coef_yy_ff, offset_y_ff;

   // control
   state_type        state_ff;
   op_type           op_ff;
   logic [CW-1:0]    count_ff;
   logic [AW-1:0]    ix_ff;
   logic             issuing_ff;
   logic             s1_vld_ff, s2_vld_ff;
   logic [AW-1:0]    s1_idx_ff, s2_idx_ff;
   logic             hit_ff;
   logic [AW-1:0]    hit_idx_ff;

   // pick query
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [2*RADIUS_W-1:0]     r2_ff;

   // result registers
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [AW-1:0]        rsp_idx_ff;
   logic [CW-1:0]        rsp_total_ff;
   logic                 rsp_rej_ff;

   // store memories, entry holds {x, y}
   logic [DW-1:0] orig_mem [MAX_VERTICES];
   logic [DW-1:0] cur_mem  [MAX_VERTICES];
   logic [DW-1:0] orig_rd_ff, cur_rd_ff;

   // pipeline data
   logic signed [DW-1:0]  p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic [DW+1:0]         sq_x_ff, sq_y_ff;

   logic        accept;
   logic        scan_op;
   logic        last_issue;
   logic        pipe_empty;
   op_type      req_op;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff == ST_RUN);
   assign csr_ready  = 1'b1;
   assign req_op     = op_type'(req_opcode);
   assign scan_op    = (req_op == OP_RESTORE) || (req_op == OP_TRANSFORM) ||
                       (req_op == OP_PICK);
   assign last_issue = (CW'(ix_ff) + CW'(1)) == count_ff;
   assign pipe_empty = !issuing_ff && !s1_vld_ff && !s2_vld_ff;

   // pick radius squared in whole units: r = floor(10 * scale / 256)
   logic [SCALE_W+3:0]  scale10;
   logic [RADIUS_W-1:0] radius;
   assign scale10 = ({req_pick_scale, 3'b000} + {2'b00, req_pick_scale, 1'b0});
   assign radius  = scale10[SCALE_W+3:8];

   // stage 1: products for transform, squared distances for pick
   logic [COORD_W-1:0]        rd_x, rd_y;
   logic signed [COORD_W:0]   dx, dy;
   assign rd_x = cur_rd_ff[DW-1:COORD_W];
   assign rd_y = cur_rd_ff[COORD_W-1:0];
   assign dx   = {qx_ff[COORD_W-1], qx_ff} - {rd_x[COORD_W-1], rd_x};
   assign dy   = {qy_ff[COORD_W-1], qy_ff} - {rd_y[COORD_W-1], rd_y};

   always_ff @(posedge clock) begin
      p_xx_ff <= coef_xx_ff * signed'(rd_x);
      p_xy_ff <= coef_xy_ff * signed'(rd_y);
      p_yx_ff <= coef_yx_ff * signed'(rd_x);
      p_yy_ff <= coef_yy_ff * signed'(rd_y);
      sq_x_ff <= (DW+2)'(dx) * (DW+2)'(dx);
      sq_y_ff <= (DW+2)'(dy) * (DW+2)'(dy);
   end

   // stage 2: round half up to q16.8, add offset, saturate
   logic signed [DW:0]   sum_x, sum_y, bias_x, bias_y;
   logic signed [32:0]   rnd_x, rnd_y;
   logic signed [33:0]   off_x, off_y;
   logic [COORD_W-1:0]   new_x, new_y;
   assign sum_x  = (DW+1)'(p_xx_ff) + (DW+1)'(p_xy_ff);
   assign sum_y  = (DW+1)'(p_yx_ff) + (DW+1)'(p_yy_ff);
   assign bias_x = sum_x + (DW+1)'(32768);
   assign bias_y = sum_y + (DW+1)'(32768);
   assign rnd_x  = 33'(bias_x >>> 16);
   assign rnd_y  = 33'(bias_y >>> 16);
   assign off_x  = 34'(rnd_x) + 34'(offset_x_ff);
   assign off_y  = 34'(rnd_y) + 34'(offset_y_ff);
   assign new_x  = sat_coord(off_x);
   assign new_y  = sat_coord(off_y);

   // stage 2: pick compare against (r * 256)^2
   logic [DW+2:0] dist_sq;
   logic          in_range;
   assign dist_sq  = (DW+3)'(sq_x_ff) + (DW+3)'(sq_y_ff);
   assign in_range = dist_sq < (DW+3)'({r2_ff, 16'h0000});

   // memory write selection; each entry is read once before its write-back,
   // so reads ahead never touch an entry being written
   logic          orig_we, cur_we;
   logic [AW-1:0] orig_waddr, cur_waddr;
   logic [DW-1:0] orig_wdata, cur_wdata;
   logic          load_ok;

   assign load_ok    = count_ff < CW'(MAX_VERTICES);
   assign orig_we    = accept && (req_op == OP_LOAD) && load_ok;
   assign orig_waddr = count_ff[AW-1:0];
   assign orig_wdata = {req_coord_x, req_coord_y};

   always_comb begin
      cur_we    = 1'b0;
      cur_waddr = count_ff[AW-1:0];
      cur_wdata = {req_coord_x, req_coord_y};
      if (orig_we) begin
         cur_we = 1'b1;
      end else if (s1_vld_ff && (op_ff == OP_RESTORE)) begin
         cur_we    = 1'b1;
         cur_waddr = s1_idx_ff;
         cur_wdata = orig_rd_ff;
      end else if (s2_vld_ff && (op_ff == OP_TRANSFORM)) begin
         cur_we    = 1'b1;
         cur_waddr = s2_idx_ff;
         cur_wdata = {new_x, new_y};
      end
   end

   // original copy
   always_ff @(posedge clock) begin
      if (orig_we) begin
         orig_mem[orig_waddr] <= orig_wdata;
      end
      orig_rd_ff <= orig_mem[ix_ff];
   end

   // current copy
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      cur_rd_ff <= cur_mem[ix_ff];
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff  <= COEF_ONE;
         coef_xy_ff  <= COEF_ZERO;
         offset_x_ff <= COEF_ZERO;
         coef_yx_ff  <= COEF_ZERO;
         coef_yy_ff  <= COEF_ONE;
         offset_y_ff <= COEF_ZERO;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_COEF_XX:  coef_xx_ff  <= csr_wdata;
            CSR_COEF_XY:  coef_xy_ff  <= csr_wdata;
            CSR_OFFSET_X: offset_x_ff <= csr_wdata;
            CSR_COEF_YX:  coef_yx_ff  <= csr_wdata;
            CSR_COEF_YY:  coef_yy_ff  <= csr_wdata;
            CSR_OFFSET_Y: offset_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // query payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
         r2_ff <= radius * radius;
      end
      s1_idx_ff <= ix_ff;
      s2_idx_ff <= s1_idx_ff;
   end

   // control state machine and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_LOAD;
         count_ff     <= '0;
         ix_ff        <= '0;
         issuing_ff   <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         hit_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         rsp_idx_ff   <= '0;
         rsp_total_ff <= '0;
         rsp_rej_ff   <= 1'b0;
      end else begin
         s1_vld_ff    <= issuing_ff;
         s2_vld_ff    <= s1_vld_ff;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff      <= req_op;
                  ix_ff      <= '0;
                  hit_ff     <= 1'b0;
                  hit_idx_ff <= '0;
                  if (scan_op && (count_ff != '0)) begin
                     state_ff     <= ST_RUN;
                     issuing_ff   <= 1'b1;
                     rsp_valid_ff <= 1'b0;
                  end else begin
                     // commands that need no store scan
                     rsp_valid_ff <= 1'b1;
                     rsp_hit_ff   <= 1'b0;
                     rsp_idx_ff   <= '0;
                     rsp_rej_ff   <= (req_op == OP_LOAD) && !load_ok;
                     if (req_op == OP_CLEAR) begin
                        count_ff     <= '0;
                        rsp_total_ff <= '0;
                     end else if (orig_we) begin
                        count_ff     <= count_ff + CW'(1);
                        rsp_total_ff <= count_ff + CW'(1);
                     end else begin
                        rsp_total_ff <= count_ff;
                     end
                  end
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_RUN: begin
               // walk the store one entry a beat
               if (issuing_ff) begin
                  if (last_issue) begin
                     issuing_ff <= 1'b0;
                  end else begin
                     ix_ff <= ix_ff + AW'(1);
                  end
               end
               // first vertex in range wins
               if (s2_vld_ff && (op_ff == OP_PICK) && !hit_ff && in_range) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= s2_idx_ff;
               end
               if (pipe_empty) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_idx_ff   <= hit_idx_ff;
                  rsp_total_ff <= count_ff;
                  rsp_rej_ff   <= 1'b0;
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_hit_index     = INDEX_W'(rsp_idx_ff);
   assign rsp_vertex_total  = TOTAL_W'(rsp_total_ff);
   assign rsp_load_rejected = rsp_rej_ff;

endmodule

### test/vat_checker.sv
`timescale 1ns / 1ps
// vat_checker: scoreboard for the vertex affine transform and pick block
// watches command, result and register beats, predicts every result and compares
// depends on vat_pkg
module vat_checker
   import vat_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [SCALE_W-1:0]        req_pick_scale,
   input  logic                      rsp_valid,
   input  logic                      rsp_hit,
   input  logic [INDEX_W-1:0]        rsp_hit_index,
   input  logic [TOTAL_W-1:0]        rsp_vertex_total,
   input  logic                      rsp_load_rejected,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic signed [COORD_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        hit_total,
   output int                        reject_total,
   output int                        checked_total
);

   typedef struct {
      logic               hit;
      logic [INDEX_W-1:0] hit_index;
      logic [TOTAL_W-1:0] vertex_total;
      logic               load_rejected;
   } vertex_outcome_type;

   // shadow of the vertex store and the matrix registers
   logic signed [COORD_W-1:0] orig_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] orig_y [MAX_VERTICES];
   logic signed [COORD_W-1:0] cur_x  [MAX_VERTICES];
   logic signed [COORD_W-1:0] cur_y  [MAX_VERTICES];
   int                        stored;
   logic signed [COORD_W-1:0] m_xx, m_xy, m_ox, m_yx, m_yy, m_oy;

   vertex_outcome_type outcome_q [$];
   int              fails;
   int              hits;
   int              rejects;
   int              checked;

   // one coordinate of the affine map: round half up to Q16.8, add offset, clamp
   function automatic logic signed [COORD_W-1:0] map_coord(input longint a, input longint b,
                                                           input longint off,
                                                           input longint x, input longint y);
      longint acc;
      acc = a * x + b * y;
      acc = ((acc + 64'sd32768) >>> 16) + off;
      if (acc < -64'sd8388608) begin
         return -24'sd8388608;
      end else if (acc > 64'sd8388607) begin
         return 24'sd8388607;
      end
      return acc[COORD_W-1:0];
   endfunction

   // advance the shadow store by one command and produce its result
   task automatic apply_command(input logic [OP_W-1:0] op,
                                input logic signed [COORD_W-1:0] qx,
                                input logic signed [COORD_W-1:0] qy,
                                input logic [SCALE_W-1:0] scale,
                                output vertex_outcome_type res);
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      longint                    radius;
      longint                    lim;
      longint                    dx;
      longint                    dy;
      res.hit           = 1'b0;
      res.hit_index     = '0;
      res.load_rejected = 1'b0;
      case (op)
         OP_LOAD: begin
            if (stored < MAX_VERTICES) begin
               orig_x[stored] = qx;
               orig_y[stored] = qy;
               cur_x[stored]  = qx;
               cur_y[stored]  = qy;
               stored++;
            end else begin
               res.load_rejected = 1'b1;
            end
         end
         OP_CLEAR: begin
            stored = 0;
         end
         OP_RESTORE: begin
            for (int i = 0; i < stored; i++) begin
               cur_x[i] = orig_x[i];
               cur_y[i] = orig_y[i];
            end
         end
         OP_TRANSFORM: begin
            for (int i = 0; i < stored; i++) begin
               nx = map_coord(m_xx, m_xy, m_ox, cur_x[i], cur_y[i]);
               ny = map_coord(m_yx, m_yy, m_oy, cur_x[i], cur_y[i]);
               cur_x[i] = nx;
               cur_y[i] = ny;
            end
         end
         OP_PICK: begin
            radius = ((PICK_FACTOR * longint'(scale)) >>> 8) * 256;
            lim    = radius * radius;
            for (int i = 0; i < stored; i++) begin
               dx = longint'(qx) - longint'(cur_x[i]);
               dy = longint'(qy) - longint'(cur_y[i]);
               if (dx * dx + dy * dy < lim) begin
                  res.hit       = 1'b1;
                  res.hit_index = i[INDEX_W-1:0];
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      res.vertex_total = stored[TOTAL_W-1:0];
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("[%0t] result %0d mismatch on %s: got %0d, want %0d",
               $time, checked, field, got, want);
      fails++;
   endtask

   // beats are sampled on the rising edge; results are checked before a new
   // command is predicted since any result on this edge belongs to an older one
   always @(posedge clock) begin
      vertex_outcome_type want;
      vertex_outcome_type pred;
      if (reset) begin
         stored = 0;
         m_xx = COEF_ONE;
         m_xy = COEF_ZERO;
         m_ox = COEF_ZERO;
         m_yx = COEF_ZERO;
         m_yy = COEF_ONE;
         m_oy = COEF_ZERO;
         outcome_q.delete();
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_XX:  m_xx = csr_wdata;
               CSR_COEF_XY:  m_xy = csr_wdata;
               CSR_OFFSET_X: m_ox = csr_wdata;
               CSR_COEF_YX:  m_yx = csr_wdata;
               CSR_COEF_YY:  m_yy = csr_wdata;
               CSR_OFFSET_Y: m_oy = csr_wdata;
               default: begin
               end
            endcase
         end
         // result beat
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result with no command outstanding", 1, 0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_hit_index !== want.hit_index)
                  report_mismatch("hit_index", rsp_hit_index, want.hit_index);
               if (rsp_vertex_total !== want.vertex_total)
                  report_mismatch("vertex_total", rsp_vertex_total, want.vertex_total);
               if (rsp_load_rejected !== want.load_rejected)
                  report_mismatch("load_rejected", rsp_load_rejected, want.load_rejected);
               if (want.hit) hits++;
               if (want.load_rejected) rejects++;
            end
            checked++;
         end
         // command beat
         if (start && !busy) begin
            apply_command(req_opcode, req_coord_x, req_coord_y, req_pick_scale, pred);
            outcome_q.push_back(pred);
         end
      end
      fail_count    <= fails;
      pending       <= outcome_q.size();
      hit_total     <= hits;
      reject_total  <= rejects;
      checked_total <= checked;
   end

   initial begin
      fails   = 0;
      hits    = 0;
      rejects = 0;
      checked = 0;
      stored  = 0;
   end

endmodule

### test/vertex_affine_transform_pick_tb.sv
`timescale 1ns / 1ps
// vertex_affine_transform_pick_tb: stimulus and verdict for the vertex transform and pick block
// drives commands and register writes, the scoreboard in vat_checker does the checking
// depends on vat_pkg, vertex_affine_transform_pick and vat_checker
module vertex_affine_transform_pick_tb;
   import vat_pkg::*;

   localparam int                PHASE_ITEMS    = 185;
   localparam int                IDLE_LIMIT     = 4000;
   localparam int                CALM_FIRST     = 700;
   localparam int                CALM_LAST      = 900;
   localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
   localparam logic signed [COORD_W-1:0] C_MAX = 24'sd8388607;
   localparam logic signed [COORD_W-1:0] C_MIN = -24'sd8388608;
   localparam logic [SCALE_W-1:0] S_MAX = 16'hFFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_opcode = OP_CLEAR;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic [SCALE_W-1:0]        req_pick_scale = '0;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic [INDEX_W-1:0]        rsp_hit_index;
   logic [TOTAL_W-1:0]        rsp_vertex_total;
   logic                      rsp_load_rejected;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_COEF_XX;
   logic signed [COORD_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int hit_total;
   int reject_total;
   int checked_total;

   int items_sent = 0;
   int settings_used = 0;
   int op_seen [8];
   int idle_cycles = 0;

   // coordinates loaded since the last clear, used to aim picks
   logic signed [COORD_W-1:0] aim_x [$];
   logic signed [COORD_W-1:0] aim_y [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   vertex_affine_transform_pick dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_pick_scale    (req_pick_scale),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_vertex_total  (rsp_vertex_total),
      .rsp_load_rejected (rsp_load_rejected),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   vat_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_pick_scale    (req_pick_scale),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_vertex_total  (rsp_vertex_total),
      .rsp_load_rejected (rsp_load_rejected),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending),
      .hit_total         (hit_total),
      .reject_total      (reject_total),
      .checked_total     (checked_total)
   );

   // watchdog: ends the run after a long stretch without any beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, pending);
         $display("** vertex_affine_transform_pick: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = int'($urandom());
         3, 4, 5: v = int'($urandom_range(0, 8191)) - 4096;
         6, 7:    v = int'($urandom_range(0, 262143)) - 131072;
         default: begin
            case ($urandom_range(0, 4))
               0:       v = C_MAX;
               1:       v = C_MIN;
               2:       v = 0;
               3:       v = -1;
               default: v = 1;
            endcase
         end
      endcase
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [SCALE_W-1:0] rand_scale();
      case ($urandom_range(0, 9))
         0, 1, 2:    return SCALE_W'($urandom());
         3, 4, 5, 6: return SCALE_W'($urandom_range(0, 600));
         7:          return S_MAX;
         8:          return '0;
         default:    return SCALE_W'($urandom_range(25, 26));
      endcase
   endfunction

   // one command beat; start is only lowered for a gap, never around a beat
   task automatic issue(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] x,
                        input logic signed [COORD_W-1:0] y, input logic [SCALE_W-1:0] s);
      if ((items_sent < CALM_FIRST || items_sent >= CALM_LAST) &&
          $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_coord_x    <= x;
      req_coord_y    <= y;
      req_pick_scale <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      op_seen[op]++;
      if (op == OP_CLEAR) begin
         aim_x.delete();
         aim_y.delete();
      end else if (op == OP_LOAD && aim_x.size() < MAX_VERTICES_DEF) begin
         aim_x.push_back(x);
         aim_y.push_back(y);
      end
   endtask

   task automatic issue_random(input logic [OP_W-1:0] op);
      issue(op, rand_coord(), rand_coord(), rand_scale());
   endtask

   // pick aimed near a loaded vertex so that hits and near misses both occur
   task automatic issue_aimed_pick();
      int k;
      if (aim_x.size() == 0) begin
         issue_random(OP_PICK);
      end else begin
         k = $urandom_range(0, aim_x.size() - 1);
         issue(OP_PICK, aim_x[k] + COORD_W'(int'($urandom_range(0, 1023)) - 512),
               aim_y[k] + COORD_W'(int'($urandom_range(0, 1023)) - 512), rand_scale());
      end
   endtask

   // hold off commands until the scoreboard has nothing outstanding
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // write all six matrix registers, block idle
   task automatic program_matrix(input logic signed [COORD_W-1:0] vals [6]);
      csr_idx_type regs [6];
      regs = '{CSR_COEF_XX, CSR_COEF_XY, CSR_OFFSET_X, CSR_COEF_YX, CSR_COEF_YY, CSR_OFFSET_Y};
      drain();
      for (int i = 0; i < 6; i++) begin
         if ($urandom_range(0, 99) < 31) begin
            csr_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_span(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return v[COORD_W-1:0];
   endfunction

   // register setting for each random phase, extremes included
   task automatic phase_setting(input int n, output logic signed [COORD_W-1:0] vals [6]);
      case (n)
         0: vals = '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO};
         1: vals = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX};
         2: vals = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN};
         3: vals = '{24'sd46341, -24'sd46341, rand_span(65536),
                     24'sd46341, 24'sd46341, rand_span(65536)};
         4: vals = '{24'sd131072, 24'sd16384, -24'sd65536,
                     -24'sd8192, 24'sd98304, 24'sd4096};
         5: vals = '{COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()),
                     COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom())};
         6: vals = '{rand_span(131072), rand_span(131072), rand_span(65536),
                     rand_span(131072), rand_span(131072), rand_span(65536)};
         default: vals = '{COEF_ONE, COEF_ZERO, C_MAX, COEF_ZERO, COEF_ONE, C_MIN};
      endcase
   endtask

   // a clear, a run of loads, then operations on the new store
   task automatic well_formed_sequence();
      int n;
      int roll;
      issue_random(OP_CLEAR);
      roll = $urandom_range(0, 99);
      if (roll < 80)      n = $urandom_range(1, 10);
      else if (roll < 92) n = $urandom_range(11, 40);
      else                n = $urandom_range(60, 70);
      repeat (n) issue_random(OP_LOAD);
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 5))
            0:       issue_random(OP_TRANSFORM);
            1:       issue_random(OP_RESTORE);
            2, 3:    issue_aimed_pick();
            4:       issue_random(OP_PICK);
            default: issue_random(OP_LOAD);
         endcase
      end
   endtask

   initial begin
      logic signed [COORD_W-1:0] vals [6];
      int phase_end;
      int spare;

      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, coordinate extremes, radius edges, spare opcodes
      issue(OP_PICK, '0, '0, S_MAX);
      issue(OP_RESTORE, C_MAX, C_MIN, S_MAX);
      issue(OP_TRANSFORM, C_MIN, C_MAX, '0);
      issue(OP_LOAD, C_MAX, C_MAX, '0);
      issue(OP_LOAD, C_MIN, C_MIN, S_MAX);
      issue(OP_LOAD, '0, '0, '0);
      issue(OP_LOAD, C_MIN, C_MAX, '0);
      issue(OP_PICK, '0, '0, '0);
      issue(OP_PICK, '0, '0, 16'd26);
      issue(OP_PICK, 24'sd256, '0, 16'd26);
      issue(OP_PICK, 24'sd1, '0, 16'd26);
      issue(OP_PICK, C_MAX, C_MAX, S_MAX);
      issue(OP_PICK, C_MIN, C_MIN, 16'd25);
      issue(OP_TRANSFORM, '0, '0, '0);
      issue(OP_PICK, C_MIN, C_MAX, 16'd26);
      issue(OP_RESTORE, '0, '0, '0);
      for (logic [OP_W:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         issue(op[OP_W-1:0], 24'sh555555, 24'shAAAAAA, 16'hA5A5);
      issue(OP_CLEAR, 24'shAAAAAA, 24'sh555555, 16'h5A5A);
      issue(OP_PICK, '0, '0, S_MAX);
      issue(OP_LOAD, 24'sh555555, 24'shAAAAAA, 16'h5A5A);
      issue(OP_PICK, 24'sh555555, 24'shAAAAAA, 16'd26);

      // random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         phase_setting(ph, vals);
         program_matrix(vals);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 70) begin
               well_formed_sequence();
            end else begin
               repeat ($urandom_range(1, 4)) issue_random(OP_W'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 99) < 2) drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      spare = 0;
      for (int i = OP_SPARE_FIRST; i <= OP_SPARE_LAST; i++) spare += op_seen[i];
      $display("ran %0d commands: load %0d, clear %0d, restore %0d, transform %0d, pick %0d,",
               items_sent, op_seen[OP_LOAD], op_seen[OP_CLEAR], op_seen[OP_RESTORE],
               op_seen[OP_TRANSFORM], op_seen[OP_PICK]);
      $display("spare %0d; %0d matrix settings, %0d results compared, %0d hits, %0d full loads",
               spare, settings_used, checked_total, hit_total, reject_total);
      if (fail_count == 0 && pending == 0) begin
         $display("** vertex_affine_transform_pick: PASSED **");
      end else begin
         $display("** vertex_affine_transform_pick: FAILED **");
      end
      $finish;
   end

endmodule

### vertex_affine_transform_pick.f
design/vat_pkg.sv
design/vertex_affine_transform_pick.sv
test/vat_checker.sv
test/vertex_affine_transform_pick_tb.sv
